/* rtl/rcss_pkg.sv */
// shared types and constants of the collective step schedule block
package rcss_pkg;

	// field widths
	localparam int STEP_W     = 4;
	localparam int LSTEP_W    = 3;
	localparam int OUT_W      = 6;
	localparam int RCNT_W     = 7;
	localparam int POS_W      = 6;
	localparam int TSTEP_W    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// dividend width of the remainder unit: holds a position or a distance up to 64
	localparam int D_W = 7;

	// most slices emitted for one step
	localparam int MAX_OUT = 32;

	// phase codes
	localparam logic PHASE_RS = 1'b0;
	localparam logic PHASE_AG = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RANK_COUNT  = 2'd0,
		CFG_MY_POSITION = 2'd1,
		CFG_TOTAL_STEPS = 2'd2
	} cfg_reg_t;

endpackage

/* rtl/rcss_mod_unit.sv */
// shared restoring remainder unit, one dividend bit per cycle
module rcss_mod_unit #(
	parameter int XW = 7,
	parameter int RW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [XW-1:0] x,
	input  logic [RW-1:0] divisor,
	output logic          done,
	output logic [RW-1:0] rem
);

	localparam int CW = $clog2(XW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [XW-1:0] x_q;
	logic [RW-1:0] rem_q;

	logic [RW:0]   trial;
	logic          ge;
	logic [RW-1:0] next_rem;

	// one shift-subtract step
	assign trial    = {rem_q, x_q[XW-1]};
	assign ge       = trial >= {1'b0, divisor};
	assign next_rem = ge ? RW'(trial - {1'b0, divisor}) : RW'(trial);

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(XW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// dividend and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			rem_q <= '0;
		end else if (busy_q) begin
			x_q   <= x_q << 1;
			rem_q <= next_rem;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

/* rtl/ring_collective_step_schedule.sv */
// top level of the collective step schedule block
// For each accepted step number the block works out the send and receive peers and the slice
// count of that step in a reduce-scatter / all-gather schedule, then emits one result per
// slice with the transmit and receive slice indices, the final one marked last; a step with
// no slices gives one result with cleared slice indices. Before the first result is offered,
// the one shared remainder unit makes two passes of 7 shift steps each, handing over the
// remainder after each, which reduce the position and then the step distance modulo the rank
// count, and the peers are then formed in ST_PEERS. Then one result per cycle for up to 32
// slices while the output side takes them. A step not below the total, or a total below two,
// gives a single error result the cycle after it is accepted. Input is accepted only once all
// results of the previous item have been taken.
module ring_collective_step_schedule #(
	parameter int MAX_RANKS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rcss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rcss_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rcss_pkg::STEP_W-1:0]       step_index,
	// output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              phase,
	output logic [rcss_pkg::LSTEP_W-1:0]      local_step,
	output logic [rcss_pkg::OUT_W-1:0]        to_rank,
	output logic [rcss_pkg::OUT_W-1:0]        from_rank,
	output logic [rcss_pkg::OUT_W-1:0]        slice_count,
	output logic [rcss_pkg::OUT_W-1:0]        tx_slice,
	output logic [rcss_pkg::OUT_W-1:0]        rx_slice,
	output logic                              last,
	output logic                              error
);

	import rcss_pkg::*;

	localparam int RW    = $clog2(MAX_RANKS) + 1;
	localparam int EW    = RW + 1;
	localparam int SUM_W = ((RW > D_W) ? RW : D_W) + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD_P,
		ST_MOD_D,
		ST_PEERS,
		ST_EMIT
	} state_t;

	// (a - b) mod r for a, b below r
	function automatic logic [RW-1:0] sub_mod(input logic [RW-1:0] a, input logic [RW-1:0] b,
		input logic [RW-1:0] r);
		logic [EW-1:0] wrap;
		wrap = EW'(a) + EW'(r) - EW'(b);
		return (a >= b) ? RW'(a - b) : RW'(wrap);
	endfunction

	// (a + b) mod r for a, b below r
	function automatic logic [RW-1:0] add_mod(input logic [RW-1:0] a, input logic [RW-1:0] b,
		input logic [RW-1:0] r);
		logic [EW-1:0] sum;
		sum = EW'(a) + EW'(b);
		return (sum >= EW'(r)) ? RW'(sum - EW'(r)) : RW'(sum);
	endfunction

	// configuration registers
	logic [RCNT_W-1:0]  rank_count_q;
	logic [POS_W-1:0]   my_position_q;
	logic [TSTEP_W-1:0] total_steps_q;

	// sequencer state and result registers
	state_t             state_q;
	logic               out_valid_q;
	logic               phase_q;
	logic [LSTEP_W-1:0] local_step_q;
	logic [2:0]         sh_q;
	logic [RW-1:0]      p_q;
	logic [RW-1:0]      dm_q;
	logic [RW-1:0]      ddm_q;
	logic [RW-1:0]      to_q;
	logic [RW-1:0]      from_q;
	logic [OUT_W-1:0]   cnt_q;
	logic [OUT_W-1:0]   left_q;
	logic [RW-1:0]      tx_q;
	logic [RW-1:0]      rx_q;
	logic               last_q;
	logic               error_q;

	// combinational helpers
	logic [RW-1:0]      r_c;
	logic [2:0]         half_c;
	logic               step_err;
	logic [STEP_W-1:0]  diff_c;
	logic [LSTEP_W-1:0] s_ag;
	logic               in_fire;
	logic               out_fire;
	logic [D_W-1:0]     d_c;
	logic               mod_start;
	logic [D_W-1:0]     mod_x;
	logic               mod_done;
	logic [RW-1:0]      mod_rem;
	logic [RW-1:0]      p_minus;
	logic [RW-1:0]      p_plus;
	logic [RW-1:0]      ddm_c;
	logic [SUM_W-1:0]   n_sum;
	logic [SUM_W-1:0]   n_c;
	logic [OUT_W-1:0]   cnt_c;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_count_q  <= RCNT_W'(2);
			my_position_q <= '0;
			total_steps_q <= TSTEP_W'(2);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RANK_COUNT:  rank_count_q  <= cfg_data[RCNT_W-1:0];
				CFG_MY_POSITION: my_position_q <= cfg_data[POS_W-1:0];
				CFG_TOTAL_STEPS: total_steps_q <= cfg_data[TSTEP_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped rank count
	always_comb begin
		if (rank_count_q < RCNT_W'(2)) begin
			r_c = RW'(2);
		end else if (int'(rank_count_q) > MAX_RANKS) begin
			r_c = RW'(MAX_RANKS);
		end else begin
			r_c = RW'(rank_count_q);
		end
	end

	// step decode
	assign half_c   = total_steps_q[TSTEP_W-1:1];
	assign step_err = (step_index >= total_steps_q) || (half_c == 3'd0);
	assign diff_c   = step_index - {1'b0, half_c};
	assign s_ag     = (diff_c >= {1'b0, half_c}) ? LSTEP_W'(diff_c - {1'b0, half_c})
		: LSTEP_W'(diff_c);

	// shared remainder unit: position first, then step distance
	assign d_c       = D_W'(1) << sh_q;
	assign mod_start = (state_q == ST_IDLE && in_fire && !step_err) ||
		(state_q == ST_MOD_P && mod_done);
	assign mod_x     = (state_q == ST_IDLE) ? D_W'(my_position_q) : d_c;

	rcss_mod_unit #(
		.XW(D_W),
		.RW(RW)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.x       (mod_x),
		.divisor (r_c),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	// peers, doubled distance and slice count
	assign p_minus = sub_mod(p_q, dm_q, r_c);
	assign p_plus  = add_mod(p_q, dm_q, r_c);
	assign ddm_c   = add_mod(dm_q, dm_q, r_c);
	assign n_sum   = SUM_W'(r_c) - SUM_W'(1) + SUM_W'(d_c);
	assign n_c     = n_sum >> ({1'b0, sh_q} + 4'd1);
	assign cnt_c   = (n_c > SUM_W'(MAX_OUT)) ? OUT_W'(MAX_OUT) : OUT_W'(n_c);

	// sequencer and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			phase_q      <= PHASE_RS;
			local_step_q <= '0;
			sh_q         <= '0;
			p_q          <= '0;
			dm_q         <= '0;
			ddm_q        <= '0;
			to_q         <= '0;
			from_q       <= '0;
			cnt_q        <= '0;
			left_q       <= '0;
			tx_q         <= '0;
			rx_q         <= '0;
			last_q       <= 1'b0;
			error_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (step_err) begin
							phase_q      <= PHASE_RS;
							local_step_q <= '0;
							to_q         <= '0;
							from_q       <= '0;
							cnt_q        <= '0;
							tx_q         <= '0;
							rx_q         <= '0;
							last_q       <= 1'b1;
							error_q      <= 1'b1;
							out_valid_q  <= 1'b1;
							state_q      <= ST_EMIT;
						end else if (step_index < {1'b0, half_c}) begin
							phase_q      <= PHASE_RS;
							local_step_q <= LSTEP_W'(step_index);
							sh_q         <= step_index[2:0];
							state_q      <= ST_MOD_P;
						end else begin
							phase_q      <= PHASE_AG;
							local_step_q <= s_ag;
							sh_q         <= half_c - 3'd1 - s_ag;
							state_q      <= ST_MOD_P;
						end
					end
				end
				ST_MOD_P: begin
					if (mod_done) begin
						p_q     <= mod_rem;
						state_q <= ST_MOD_D;
					end
				end
				ST_MOD_D: begin
					if (mod_done) begin
						dm_q    <= mod_rem;
						state_q <= ST_PEERS;
					end
				end
				ST_PEERS: begin
					ddm_q   <= ddm_c;
					error_q <= 1'b0;
					if (phase_q == PHASE_RS) begin
						to_q   <= p_minus;
						from_q <= p_plus;
					end else begin
						to_q   <= p_plus;
						from_q <= p_minus;
					end
					// zero slices: one result with cleared slice indices
					if (cnt_c == '0) begin
						tx_q <= '0;
						rx_q <= '0;
					end else if (phase_q == PHASE_RS) begin
						tx_q <= p_minus;
						rx_q <= p_q;
					end else begin
						tx_q <= p_q;
						rx_q <= p_minus;
					end
					cnt_q  <= cnt_c;
					left_q <= cnt_c - OUT_W'(1);
					last_q <= (cnt_c <= OUT_W'(1));
					out_valid_q <= 1'b1;
					state_q     <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_fire) begin
						if (last_q) begin
							out_valid_q <= 1'b0;
							state_q     <= ST_IDLE;
						end else begin
							tx_q   <= sub_mod(tx_q, ddm_q, r_c);
							rx_q   <= sub_mod(rx_q, ddm_q, r_c);
							left_q <= left_q - OUT_W'(1);
							last_q <= (left_q == OUT_W'(1));
						end
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign phase       = phase_q;
	assign local_step  = local_step_q;
	assign to_rank     = OUT_W'(to_q);
	assign from_rank   = OUT_W'(from_q);
	assign slice_count = cnt_q;
	assign tx_slice    = OUT_W'(tx_q);
	assign rx_slice    = OUT_W'(rx_q);
	assign last        = last_q;
	assign error       = error_q;

	// no new transaction while results of the previous one are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> !out_valid_q)
		else $error("input accepted while results pending");

	// an error result always closes its step
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && error_q |-> last_q)
		else $error("error result not marked last");

	// peers stay below the rank count
	a_peer_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !error_q |-> (to_q < r_c) && (from_q < r_c))
		else $error("peer rank out of range");

	// remainder unit finishes only while the sequencer waits for it
	a_mod_done: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == ST_MOD_P) || (state_q == ST_MOD_D))
		else $error("remainder unit done outside its states");

endmodule
